[hw/rtl/meter_pulse_rate_counter_core_defines.svh]
// assertion macros for the meter pulse rate counter core
// included by the top level only; expects i_clk and i_rst_n in scope
`ifndef METER_PULSE_RATE_COUNTER_CORE_DEFINES_SVH
`define METER_PULSE_RATE_COUNTER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define MPRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MPRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/mprc_pkg.sv]
// shared types and constants for the meter pulse rate counter core
// no dependencies; imported by controller, datapath and top level
package mprc_pkg;

    localparam int CNT_W    = 24;
    localparam int RATE_W   = 22;
    localparam int TOTAL_W  = 32;
    localparam int PULSE_W  = 16;
    localparam int WIN_W    = 22;
    localparam int CFG_W    = 22;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_CNT_W = $clog2(RATE_W);

    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [RATE_W-1:0] RATE_MAX = '1;

    localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 16'd20;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 16'd200;
    localparam logic [WIN_W-1:0]   WINDOW_RST    = 22'd10000;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DINIT,
        S_DIV,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic tick_en;
        logic mul_en;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic win_close;
        logic div_last;
        logic out_free;
    } t_dp_sts;

endpackage

[hw/rtl/meter_pulse_rate_counter_core.sv]
// top level of the meter pulse rate counter core
// depends on mprc_pkg, mprc_ctrl, mprc_dp and the core defines header
//
// usage:
//   input channel: one word per millisecond tick, i_sensor_level (0 = pulse
//   present). a word is taken when i_in_valid is high and o_in_stall is low.
//   output channel: one word per closed measurement window with the window
//   count, total count, pulses-per-hour estimate and its valid flag; taken
//   when o_out_valid is high and i_out_stall is low.
//   config: i_cfg_we with i_cfg_idx 0 = min pulse, 1 = max pulse, 2 = window
//   length; other indexes are ignored. write only while idle.
// sequencing:
//   a tick that does not close a window leaves the input free for the next
//   word. a closing tick holds the input through one multiply, one divider
//   setup, 22 divider steps (one quotient bit per cycle) and the output
//   load; the load waits while the output register is still occupied.
// reset: synchronous, active low; counters and time clear, config returns
//   to 20 / 200 / 10000 ms and the output register empties.
// stall: a waiting result holds its word; ticks keep flowing until the next
//   closing tick, which waits in the last step for the register to free up.
`include "meter_pulse_rate_counter_core_defines.svh"

module meter_pulse_rate_counter_core
    import mprc_pkg::*;
#(
    parameter int MS_PER_HOUR = 3600000,
    parameter int TIME_BITS   = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_sensor_level,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CNT_W-1:0]     o_window_pulses,
    output logic [RATE_W-1:0]    o_pulses_per_hour,
    output logic                 o_rate_valid,
    output logic [TOTAL_W-1:0]   o_total_pulses
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    mprc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    mprc_dp #(
        .MS_PER_HOUR (MS_PER_HOUR),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_sensor_level    (i_sensor_level),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_window_pulses   (o_window_pulses),
        .o_pulses_per_hour (o_pulses_per_hour),
        .o_rate_valid      (o_rate_valid),
        .o_total_pulses    (o_total_pulses)
    );

    // a closing tick must start the rate computation and hold off new words
    `MPRC_ASSERT_NEXT(a_close_stalls, i_in_valid && !o_in_stall && sts.win_close, o_in_stall, "closing tick did not stall input")

    // a zero interval reports a zero rate
    `MPRC_ASSERT_NOW(a_zero_rate, o_out_valid && !o_rate_valid, o_pulses_per_hour == '0, "invalid rate is not zero")

    // a window only closes after at least one good pulse
    `MPRC_ASSERT_NOW(a_count_nonzero, o_out_valid, o_window_pulses != '0, "empty window reported")

endmodule

[hw/rtl/mprc_ctrl.sv]
// sequencing fsm for the meter pulse rate counter core
// depends on mprc_pkg; drives commands into mprc_dp
module mprc_ctrl
    import mprc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_sts.win_close) n_state = S_MUL;
            end
            S_MUL:   n_state = S_DINIT;
            S_DINIT: n_state = S_DIV;
            S_DIV: begin
                if (i_sts.div_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.tick_en = i_in_valid;
            end
            S_MUL:   o_cmd.mul_en   = 1'b1;
            S_DINIT: o_cmd.div_init = 1'b1;
            S_DIV:   o_cmd.div_step = 1'b1;
            S_DONE:  o_cmd.out_load = i_sts.out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

[hw/rtl/mprc_dp.sv]
// datapath: config registers, tick state, rate multiply and radix-2 divider
// depends on mprc_pkg; sequenced by mprc_ctrl
module mprc_dp
    import mprc_pkg::*;
#(
    parameter int MS_PER_HOUR = 3600000,
    parameter int TIME_BITS   = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_sensor_level,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [CNT_W-1:0]     o_window_pulses,
    output logic [RATE_W-1:0]    o_pulses_per_hour,
    output logic                 o_rate_valid,
    output logic [TOTAL_W-1:0]   o_total_pulses
);

    localparam int MSH_W = $clog2(MS_PER_HOUR + 1);
    localparam int PW    = CNT_W + MSH_W;
    localparam int HI_W  = PW - RATE_W;
    localparam int CMP_W = (HI_W > TIME_BITS) ? HI_W : TIME_BITS;
    localparam logic [MSH_W-1:0] MSH = MSH_W'(MS_PER_HOUR);

    // configuration
    logic [PULSE_W-1:0] r_min_pulse;
    logic [PULSE_W-1:0] r_max_pulse;
    logic [WIN_W-1:0]   r_window;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_pulse <= MIN_PULSE_RST;
            r_max_pulse <= MAX_PULSE_RST;
            r_window    <= WINDOW_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MIN_PULSE: r_min_pulse <= i_cfg_data[PULSE_W-1:0];
                REG_MAX_PULSE: r_max_pulse <= i_cfg_data[PULSE_W-1:0];
                REG_WINDOW:    r_window    <= i_cfg_data[WIN_W-1:0];
                default:       r_window    <= r_window;
            endcase
        end
    end

    // tick state
    logic [TIME_BITS-1:0] r_now;
    logic                 r_in_pulse;
    logic [TIME_BITS-1:0] r_pulse_start;
    logic                 r_measuring;
    logic [TIME_BITS-1:0] r_win_start;
    logic [TIME_BITS-1:0] r_last_end;
    logic [CNT_W-1:0]     r_win_count;
    logic [TOTAL_W-1:0]   r_total;

    logic                 n_in_pulse;
    logic [TIME_BITS-1:0] n_pulse_start;
    logic                 n_measuring;
    logic [TIME_BITS-1:0] n_win_start;
    logic [TIME_BITS-1:0] n_last_end;
    logic [CNT_W-1:0]     n_win_count;
    logic [TOTAL_W-1:0]   n_total;
    logic [TIME_BITS-1:0] pulse_len;
    logic [TIME_BITS-1:0] win_age;
    logic                 pulse_ok;
    logic                 win_close;

    always_comb begin
        n_in_pulse    = r_in_pulse;
        n_pulse_start = r_pulse_start;
        n_measuring   = r_measuring;
        n_win_start   = r_win_start;
        n_last_end    = r_last_end;
        n_win_count   = r_win_count;
        n_total       = r_total;
        pulse_ok      = 1'b0;
        pulse_len     = r_now - r_pulse_start;
        if (!r_in_pulse && !i_sensor_level) begin
            n_in_pulse    = 1'b1;
            n_pulse_start = r_now;
        end else if (r_in_pulse && i_sensor_level) begin
            n_in_pulse = 1'b0;
            pulse_ok   = (pulse_len >= TIME_BITS'(r_min_pulse))
                      && (pulse_len <= TIME_BITS'(r_max_pulse));
        end
        if (pulse_ok) begin
            // first good pulse opens the window at its close time
            if (!r_measuring) begin
                n_measuring = 1'b1;
                n_win_start = r_now;
            end
            if (r_win_count != CNT_MAX) n_win_count = r_win_count + 1'b1;
            n_total    = r_total + 1'b1;
            n_last_end = r_now;
        end
        win_age   = r_now - n_win_start;
        win_close = n_measuring && (win_age > TIME_BITS'(r_window));
    end

    // window snapshot taken on the closing tick
    logic [CNT_W-1:0]     r_snap_count;
    logic [TOTAL_W-1:0]   r_snap_total;
    logic [TIME_BITS-1:0] r_interval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now         <= '0;
            r_in_pulse    <= 1'b0;
            r_pulse_start <= '0;
            r_measuring   <= 1'b0;
            r_win_start   <= '0;
            r_last_end    <= '0;
            r_win_count   <= '0;
            r_total       <= '0;
        end else if (i_cmd.tick_en) begin
            r_now         <= r_now + 1'b1;
            r_in_pulse    <= n_in_pulse;
            r_pulse_start <= n_pulse_start;
            r_win_start   <= n_win_start;
            r_last_end    <= n_last_end;
            r_total       <= n_total;
            r_measuring   <= n_measuring && !win_close;
            r_win_count   <= win_close ? '0 : n_win_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_en && win_close) begin
            r_snap_count <= n_win_count;
            r_snap_total <= n_total;
            r_interval   <= n_last_end - n_win_start;
        end
    end

    // (count - 1) * ms per hour
    logic [PW-1:0]    r_prod;
    logic [CNT_W-1:0] mul_cnt;

    assign mul_cnt = (r_snap_count == '0) ? '0 : r_snap_count - 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) r_prod <= PW'(mul_cnt) * PW'(MSH);
    end

    // quotient saturates when the high part already reaches the divisor,
    // else the remaining quotient bits come one per cycle
    logic [TIME_BITS:0]   r_rem;
    logic [RATE_W-1:0]    r_low;
    logic [RATE_W-1:0]    r_quo;
    logic                 r_sat;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [CMP_W-1:0]     hi_ext;
    logic [CMP_W-1:0]     div_ext;
    logic [TIME_BITS:0]   rem_sh;
    logic                 rem_ge;

    assign hi_ext  = CMP_W'(r_prod[PW-1:RATE_W]);
    assign div_ext = CMP_W'(r_interval);
    assign rem_sh  = {r_rem[TIME_BITS-1:0], r_low[RATE_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_interval};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_sat     <= hi_ext >= div_ext;
            r_rem     <= (TIME_BITS+1)'(hi_ext);
            r_low     <= r_prod[RATE_W-1:0];
            r_quo     <= '0;
            r_div_cnt <= DIV_CNT_W'(RATE_W - 1);
        end else if (i_cmd.div_step) begin
            r_rem     <= rem_ge ? rem_sh - {1'b0, r_interval} : rem_sh;
            r_low     <= {r_low[RATE_W-2:0], 1'b0};
            r_quo     <= {r_quo[RATE_W-2:0], rem_ge};
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    // output register
    logic                r_out_valid;
    logic [CNT_W-1:0]    r_out_count;
    logic [RATE_W-1:0]   r_out_rate;
    logic                r_out_rvalid;
    logic [TOTAL_W-1:0]  r_out_total;
    logic                out_free;
    logic                zero_int;

    assign out_free = !r_out_valid || !i_out_stall;
    assign zero_int = (r_interval == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_count  <= r_snap_count;
            r_out_total  <= r_snap_total;
            r_out_rvalid <= !zero_int;
            r_out_rate   <= zero_int ? '0 : (r_sat ? RATE_MAX : r_quo);
        end
    end

    assign o_sts.win_close = win_close;
    assign o_sts.div_last  = (r_div_cnt == '0);
    assign o_sts.out_free  = out_free;

    assign o_out_valid       = r_out_valid;
    assign o_window_pulses   = r_out_count;
    assign o_pulses_per_hour = r_out_rate;
    assign o_rate_valid      = r_out_rvalid;
    assign o_total_pulses    = r_out_total;

endmodule

[verif/meter_pulse_rate_counter_core_tb.sv]
// self-checking testbench for meter_pulse_rate_counter_core
// depends on mprc_pkg and the core rtl; the expected window words come from a
// behavioral tick model kept in step with every accepted input word
`timescale 1ns / 1ps

module meter_pulse_rate_counter_core_tb;
    import mprc_pkg::*;

    localparam int unsigned MS_HOUR      = 3600000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          QUIET_LIMIT  = 3000;
    localparam int          RAND_PHASES  = 8;
    localparam int          PHASE_TICKS  = 180;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic [CNT_W-1:0]   pulses;
        logic [RATE_W-1:0]  rate;
        logic               rate_ok;
        logic [TOTAL_W-1:0] total;
    } t_window_word;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx      = '0;
    logic [CFG_W-1:0]     i_cfg_data     = '0;
    logic                 i_in_valid     = 1'b0;
    logic                 i_sensor_level = 1'b1;
    logic                 i_out_stall    = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [CNT_W-1:0]     o_window_pulses;
    logic [RATE_W-1:0]    o_pulses_per_hour;
    logic                 o_rate_valid;
    logic [TOTAL_W-1:0]   o_total_pulses;

    meter_pulse_rate_counter_core DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_sensor_level    (i_sensor_level),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_window_pulses   (o_window_pulses),
        .o_pulses_per_hour (o_pulses_per_hour),
        .o_rate_valid      (o_rate_valid),
        .o_total_pulses    (o_total_pulses)
    );

    // tick model state, reset values
    logic [PULSE_W-1:0] min_len     = MIN_PULSE_RST;
    logic [PULSE_W-1:0] max_len     = MAX_PULSE_RST;
    logic [WIN_W-1:0]   win_len     = WINDOW_RST;
    logic [31:0]        now_ms      = '0;
    logic [31:0]        pulse_start = '0;
    logic [31:0]        win_start   = '0;
    logic [31:0]        last_end    = '0;
    logic               in_pulse    = 1'b0;
    logic               measuring   = 1'b0;
    logic [CNT_W-1:0]   win_cnt     = '0;
    logic [TOTAL_W-1:0] tot_cnt     = '0;

    logic         ticks_pending[$];
    t_window_word windows_due[$];

    int ticks_queued   = 0;
    int ticks_taken    = 0;
    int windows_seen   = 0;
    int cfg_writes     = 0;
    int errors         = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // advance the tick model by one millisecond
    task automatic meter_tick(input logic level);
        logic [31:0]  t;
        logic [31:0]  len;
        logic [31:0]  span;
        logic [63:0]  q;
        t_window_word w;
        t = now_ms;
        if (!in_pulse && !level) begin
            in_pulse    = 1'b1;
            pulse_start = t;
        end else if (in_pulse && level) begin
            len      = t - pulse_start;
            in_pulse = 1'b0;
            if (len >= min_len && len <= max_len) begin
                if (!measuring) begin
                    measuring = 1'b1;
                    win_start = t;
                end
                if (win_cnt != CNT_MAX) begin
                    win_cnt = win_cnt + 1'b1;
                end
                tot_cnt  = tot_cnt + 1'b1;
                last_end = t;
            end
        end
        if (measuring && (t - win_start) > {10'd0, win_len}) begin
            span      = last_end - win_start;
            w.pulses  = win_cnt;
            w.total   = tot_cnt;
            w.rate    = '0;
            w.rate_ok = 1'b0;
            if (span != 0) begin
                q = (64'(win_cnt == 0 ? 0 : win_cnt - 1'b1) * 64'(MS_HOUR)) / 64'(span);
                w.rate    = (q > 64'(RATE_MAX)) ? RATE_MAX : q[RATE_W-1:0];
                w.rate_ok = 1'b1;
            end
            windows_due.push_back(w);
            win_cnt   = '0;
            measuring = 1'b0;
        end
        now_ms = t + 1;
    endtask

    // input driver
    always @(posedge i_clk) begin : drive_ticks
        logic nv;
        logic nl;
        if (i_rst_n) begin
            nv = i_in_valid;
            nl = i_sensor_level;
            if (i_in_valid && !o_in_stall) begin
                meter_tick(i_sensor_level);
                ticks_taken = ticks_taken + 1;
                nv = 1'b0;
            end
            if (!nv && ticks_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                nl = ticks_pending.pop_front();
                nv = 1'b1;
            end
            i_in_valid     <= nv;
            i_sensor_level <= nl;
        end
    end

    // output monitor and receiver stall
    always @(posedge i_clk) begin : check_windows
        t_window_word want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                windows_seen = windows_seen + 1;
                if (windows_due.size() == 0) begin
                    $error("window word with none expected: pulses %0d total %0d",
                           o_window_pulses, o_total_pulses);
                    errors = errors + 1;
                end else begin
                    want = windows_due.pop_front();
                    if (o_window_pulses !== want.pulses) begin
                        $error("window_pulses: expected %0d, got %0d",
                               want.pulses, o_window_pulses);
                        errors = errors + 1;
                    end
                    if (o_pulses_per_hour !== want.rate) begin
                        $error("pulses_per_hour: expected %0d, got %0d",
                               want.rate, o_pulses_per_hour);
                        errors = errors + 1;
                    end
                    if (o_rate_valid !== want.rate_ok) begin
                        $error("rate_valid: expected %0d, got %0d",
                               want.rate_ok, o_rate_valid);
                        errors = errors + 1;
                    end
                    if (o_total_pulses !== want.total) begin
                        $error("total_pulses: expected %0d, got %0d",
                               want.total, o_total_pulses);
                        errors = errors + 1;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("meter_pulse_rate_counter_core regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_meter_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        cfg_writes = cfg_writes + 1;
        case (idx)
            REG_MIN_PULSE: min_len = data[PULSE_W-1:0];
            REG_MAX_PULSE: max_len = data[PULSE_W-1:0];
            REG_WINDOW:    win_len = data[WIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_meter_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (ticks_taken != ticks_queued || windows_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 74; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 74; end
            default:       begin send_idle_pct = 33; recv_stall_pct = 33; end
        endcase
    endtask

    task automatic queue_tick(input logic level);
        ticks_pending.push_back(level);
        ticks_queued = ticks_queued + 1;
    endtask

    // low for len ticks, then high for gap ticks
    task automatic queue_pulse(input int len, input int gap);
        repeat (len) queue_tick(1'b0);
        repeat (gap) queue_tick(1'b1);
    endtask

    // mostly well-formed pulses near the accepted lengths, some noise
    task automatic queue_random_ticks(input int n);
        int count;
        int lo;
        int hi;
        int len;
        int gap;
        int k;
        count = 0;
        while (count < n) begin
            if ($urandom_range(99) < 80) begin
                lo = (min_len > 1) ? int'(min_len) - 1 : 1;
                hi = int'(max_len) + 1;
                if (hi > lo + 12) hi = lo + 12;
                if (hi < lo) hi = lo;
                len = $urandom_range(hi, lo);
                if ($urandom_range(9) == 0) begin
                    gap = $urandom_range((win_len > 90) ? 100 : int'(win_len) + 10, 1);
                end else begin
                    gap = $urandom_range(4, 1);
                end
                queue_pulse(len, gap);
                count = count + len + gap;
            end else begin
                k = $urandom_range(6, 1);
                repeat (k) queue_tick(1'($urandom_range(1)));
                count = count + k;
            end
        end
    endtask

    initial begin : run_regression
        int            ph;
        int            lo;
        logic [CFG_W-1:0] hi_len;
        set_idling(IDLE_NONE);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // pulse at the reset limits opens a window of reset length
        queue_pulse(20, 1);
        wait_drained();

        // masked min, ignored index, zero window: each window closes with zero interval
        write_meter_reg(REG_UNUSED, 22'h3FFFFF);
        write_meter_reg(REG_MIN_PULSE, 22'h3F0001);
        write_meter_reg(REG_MAX_PULSE, 22'd2);
        write_meter_reg(REG_WINDOW, 22'd0);
        end_meter_writes();
        queue_tick(1'b1);
        queue_pulse(1, 1);
        queue_pulse(2, 1);
        queue_pulse(3, 1);
        wait_drained();

        // min above max accepts nothing
        write_meter_reg(REG_MIN_PULSE, 22'd65535);
        write_meter_reg(REG_MAX_PULSE, 22'd1);
        end_meter_writes();
        queue_pulse(1, 1);
        queue_pulse(2, 1);
        wait_drained();

        // widest limits and longest window; this window stays open into the next phase
        write_meter_reg(REG_MIN_PULSE, 22'd1);
        write_meter_reg(REG_MAX_PULSE, 22'd65535);
        write_meter_reg(REG_WINDOW, 22'd3600000);
        end_meter_writes();
        repeat (3) queue_pulse(1, 1);
        queue_pulse(3, 2);

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drained();
            lo = $urandom_range(4, 1);
            if (ph == 5) begin
                write_meter_reg(REG_MIN_PULSE, 22'd9);
                write_meter_reg(REG_MAX_PULSE, CFG_W'($urandom_range(8, 1)));
            end else begin
                write_meter_reg(REG_MIN_PULSE, CFG_W'(lo));
                write_meter_reg(REG_MAX_PULSE, CFG_W'($urandom_range(lo + 10, lo)));
            end
            hi_len = (ph == 7) ? CFG_W'($urandom_range(300, 100))
                               : CFG_W'($urandom_range(40, 0));
            write_meter_reg(REG_WINDOW, hi_len);
            end_meter_writes();
            set_idling(t_idle_mode'(ph % 4));
            queue_random_ticks(PHASE_TICKS);
        end

        wait_drained();
        if (windows_due.size() != 0) begin
            $error("%0d window words never arrived", windows_due.size());
            errors = errors + 1;
        end
        $display("sent %0d sensor ticks, checked %0d window words", ticks_taken, windows_seen);
        $display("across %0d register writes and four idle/stall mixes", cfg_writes);
        if (errors == 0) begin
            $display("meter_pulse_rate_counter_core regression: pass");
        end else begin
            $display("meter_pulse_rate_counter_core regression: fail");
        end
        $finish;
    end

endmodule
